[rtl/core/obf_pkg.sv]
// Shared types and constants of the overwriting byte ring buffer.
`timescale 1ns / 1ps

package obf_pkg;

	localparam int DEPTH_DEF = 64;	// ring slots
	localparam int SIZEW     = 7;	// fifo_size register width
	localparam int LENW      = 7;	// read_length width
	localparam int UCW       = 6;	// used_count width

	typedef enum logic [1:0] {
		MODE_BYTE   = 2'd0,
		MODE_READ   = 2'd1,
		MODE_STATUS = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		KIND_DATA   = 3'd0,
		KIND_BUSY   = 3'd1,
		KIND_WBLOCK = 3'd2,
		KIND_STATUS = 3'd3,
		KIND_PARKED = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WR,
		S_OVF,
		S_READ,
		S_STAT,
		S_RD,
		S_EM
	} state_t;

endpackage

[rtl/core/overwriting_byte_fifo.sv]
// Top level of the overwriting receive byte ring buffer.
`timescale 1ns / 1ps

// Usage
//   Command channel: an item is taken at a rising edge with start high and busy low.
//   mode picks a byte arrival, a read request or a status query; mode three is
//   taken and dropped with no result.
//   Results: strobe marks each result for exactly one cycle; the receiver cannot
//   stall, so every strobed cycle is a completed transfer. last marks the final
//   result of an item.
//   Timing: a status query or a read that returns no data gives its result in the
//   cycle after the command and then returns to idle. A byte arrival is stored, then
//   checked for a full ring on the one shared index step unit. A read burst passes
//   through a memory read priming state after the decision and then gives one byte
//   per cycle; a batch end that serves a parked read primes the same way after its
//   full check. The shared index unit and the single read port set this order.
//   Config: cfg_we writes fifo_size (clamped to 2..DEPTH) and empties the ring;
//   write only while busy is low.
//   Reset: indices, flags and parked read clear, fifo_size becomes DEPTH; the
//   byte store itself is not cleared.
module overwriting_byte_fifo
	import obf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       mode,
	input  logic [7:0]       data_byte,
	input  logic             batch_last,
	input  logic [LENW-1:0]  read_length,
	input  logic             nonblocking,
	input  logic             cfg_we,
	input  logic [SIZEW-1:0] cfg_data,
	output logic             strobe,
	output logic [2:0]       kind,
	output logic [7:0]       data_out,
	output logic             last,
	output logic [UCW-1:0]   used_count,
	output logic             overflow_seen
);

	localparam int IW = $clog2(DEPTH);

	logic          mem_we;
	logic [IW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;

	// sequencer owns indices, flags and the result strobe
	obf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.mode          (mode),
		.data_byte     (data_byte),
		.batch_last    (batch_last),
		.read_length   (read_length),
		.nonblocking   (nonblocking),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.mem_rdata     (mem_rdata),
		.busy          (busy),
		.strobe        (strobe),
		.kind          (kind),
		.data_out      (data_out),
		.last          (last),
		.used_count    (used_count),
		.overflow_seen (overflow_seen),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_raddr     (mem_raddr)
	);

	// byte store
	obf_ram #(.DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

[rtl/core/obf_inc.sv]
// Shared ring index step unit: increment with wrap at the ring size.
`timescale 1ns / 1ps

module obf_inc
	import obf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic [$clog2(DEPTH)-1:0]   idx,
	input  logic [$clog2(DEPTH+1)-1:0] size,
	output logic [$clog2(DEPTH)-1:0]   idx_next
);

	localparam int IW = $clog2(DEPTH);
	localparam int SW = $clog2(DEPTH+1);

	logic [SW-1:0] sum;

	assign sum      = SW'(idx) + SW'(1);
	assign idx_next = (sum >= size) ? '0 : IW'(sum);

endmodule

[rtl/core/obf_ram.sv]
// Byte ring storage: one write port, one read port with registered data.
`timescale 1ns / 1ps

module obf_ram
	import obf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/obf_ctrl.sv]
// Sequencer: ring indices, flags, parked read and burst drain.
`timescale 1ns / 1ps

module obf_ctrl
	import obf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [1:0]               mode,
	input  logic [7:0]               data_byte,
	input  logic                     batch_last,
	input  logic [LENW-1:0]          read_length,
	input  logic                     nonblocking,
	input  logic                     cfg_we,
	input  logic [SIZEW-1:0]         cfg_data,
	input  logic [7:0]               mem_rdata,
	output logic                     busy,
	output logic                     strobe,
	output logic [2:0]               kind,
	output logic [7:0]               data_out,
	output logic                     last,
	output logic [UCW-1:0]           used_count,
	output logic                     overflow_seen,
	output logic                     mem_we,
	output logic [$clog2(DEPTH)-1:0] mem_waddr,
	output logic [7:0]               mem_wdata,
	output logic [$clog2(DEPTH)-1:0] mem_raddr
);

	localparam int IW = $clog2(DEPTH);
	localparam int SW = $clog2(DEPTH+1);

	state_t          state_q, state_d;
	mode_t           mode_q;
	logic [7:0]      byte_q;
	logic            bl_q;
	logic [LENW-1:0] len_q;
	logic            nb_q;
	logic [IW-1:0]   wi_q, ri_q;
	logic [SW-1:0]   size_q, size_cfg;
	logic            ovf_q;
	logic            parked_q;
	logic [LENW-1:0] plen_q;
	logic [LENW-1:0] cnt_q;

	logic [IW-1:0]   inc_in, inc_out;
	logic [SW-1:0]   used;
	logic            accept, nonempty, em_last, serve_park;

	assign accept     = start && (state_q == S_IDLE);
	assign nonempty   = (wi_q != ri_q);
	assign em_last    = (cnt_q == LENW'(1)) || (inc_out == wi_q);
	assign serve_park = bl_q && parked_q && (plen_q != '0);

	// clamp configured size to 2..DEPTH
	always_comb begin
		if (cfg_data < SIZEW'(2)) begin
			size_cfg = SW'(2);
		end else if (32'(cfg_data) > DEPTH) begin
			size_cfg = SW'(DEPTH);
		end else begin
			size_cfg = SW'(cfg_data);
		end
	end

	always_comb begin
		if (wi_q >= ri_q) begin
			used = SW'(wi_q) - SW'(ri_q);
		end else begin
			used = size_q - SW'(ri_q) + SW'(wi_q);
		end
	end

	// one step unit, shared by write and read index advance
	assign inc_in = (state_q == S_WR) ? wi_q : ri_q;

	obf_inc #(.DEPTH(DEPTH)) u_inc (
		.idx      (inc_in),
		.size     (size_q),
		.idx_next (inc_out)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (mode_t'(mode))
						MODE_BYTE:   state_d = S_WR;
						MODE_READ:   state_d = S_READ;
						MODE_STATUS: state_d = S_STAT;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_WR:   state_d = S_OVF;
			S_OVF:  state_d = serve_park ? S_RD : S_IDLE;
			S_READ: begin
				if (!parked_q && nonempty && (len_q != '0)) begin
					state_d = S_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_STAT: state_d = S_IDLE;
			S_RD:   state_d = S_EM;
			S_EM:   state_d = em_last ? S_IDLE : S_EM;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		strobe        = 1'b0;
		kind          = KIND_DATA;
		data_out      = '0;
		last          = 1'b0;
		used_count    = '0;
		overflow_seen = 1'b0;
		mem_we        = 1'b0;
		mem_raddr     = ri_q;
		case (state_q)
			S_WR: mem_we = 1'b1;
			S_READ: begin
				if (parked_q) begin
					strobe = 1'b1;
					kind   = KIND_BUSY;
					last   = 1'b1;
				end else if (!(nonempty && (len_q != '0))) begin
					strobe = 1'b1;
					kind   = nb_q ? KIND_WBLOCK : KIND_PARKED;
					last   = 1'b1;
				end
			end
			S_STAT: begin
				strobe        = 1'b1;
				kind          = KIND_STATUS;
				last          = 1'b1;
				used_count    = UCW'(used);
				overflow_seen = ovf_q;
			end
			S_EM: begin
				strobe    = 1'b1;
				kind      = KIND_DATA;
				data_out  = mem_rdata;
				last      = em_last;
				mem_raddr = inc_out;	// prefetch the next byte
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign mem_waddr = wi_q;
	assign mem_wdata = byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wi_q     <= '0;
			ri_q     <= '0;
			size_q   <= SW'(DEPTH);
			ovf_q    <= 1'b0;
			parked_q <= 1'b0;
			plen_q   <= '0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				size_q <= size_cfg;
				wi_q   <= '0;
				ri_q   <= '0;
			end else begin
				case (state_q)
					S_WR: wi_q <= inc_out;
					S_OVF: begin
						if (!nonempty) begin
							ri_q  <= inc_out;	// full: drop oldest
							ovf_q <= 1'b1;
						end
						if (serve_park) begin
							cnt_q    <= plen_q;
							parked_q <= 1'b0;
						end
					end
					S_READ: begin
						if (!parked_q) begin
							if (nonempty && (len_q != '0)) begin
								cnt_q <= len_q;
							end else if (!nb_q) begin
								parked_q <= 1'b1;
								plen_q   <= len_q;
							end
						end
					end
					S_STAT: ovf_q <= 1'b0;
					S_EM: begin
						ri_q  <= inc_out;
						cnt_q <= cnt_q - LENW'(1);
					end
					default: ;
				endcase
			end
		end
	end

	// item capture, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(mode);
			byte_q <= data_byte;
			bl_q   <= batch_last;
			len_q  <= read_length;
			nb_q   <= nonblocking;
		end
	end

`ifndef ASSERT_OFF
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(SW'(wi_q) < size_q) && (SW'(ri_q) < size_q))
		else $error("ring index beyond size");
	a_never_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OVF) && !cfg_we |=> (wi_q != ri_q))
		else $error("ring left empty after a stored byte");
	a_drain_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EM) |-> (cnt_q != '0) && nonempty)
		else $error("drain with nothing to deliver");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !busy)
		else $error("still busy after final result");
	a_mode_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR) |-> (mode_q == MODE_BYTE))
		else $error("byte store without byte item");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the overwriting receive byte ring buffer.
`timescale 1ns / 1ps

module tb_top;
	import obf_pkg::*;

	// Cycles with no command, no busy and no strobe before the block counts as idle.
	// A byte arrival and a served burst keep busy high until they finish, so this is ample.
	localparam int SETTLE      = 6;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RAND_ITEMS  = 200;

	// fifo_size settings walked by the random phases; 1, 65 and 127 exercise the clamp
	localparam logic [SIZEW-1:0] SIZE_PLAN [8] = '{7'd1, 7'd64, 7'd127, 7'd3,
		7'd65, 7'd2, 7'd16, 7'd9};

	// What an entry of the command queue asks the driver to do
	typedef enum logic [1:0] {
		ACT_ITEM,	// one command transfer
		ACT_HOLD,	// stop sending until the block is idle and nothing is outstanding
		ACT_CFG		// write fifo_size while idle
	} step_t;

	typedef struct {
		step_t            act;
		mode_t            md;
		logic [7:0]       byt;
		logic             bl;
		logic [LENW-1:0]  len;
		logic             nb;
		logic [SIZEW-1:0] size;
		bit               may_gap;
	} rx_cmd_t;

	typedef struct {
		kind_t          k;
		logic [7:0]     d;
		logic           l;
		logic [UCW-1:0] u;
		logic           o;
	} rx_result_t;

	logic clk;
	logic arst_n = 1'b0;

	// DUT inputs, all known from time zero
	logic             start       = 1'b0;
	logic [1:0]       mode        = MODE_BYTE;
	logic [7:0]       data_byte   = '0;
	logic             batch_last  = 1'b0;
	logic [LENW-1:0]  read_length = '0;
	logic             nonblocking = 1'b0;
	logic             cfg_we      = 1'b0;
	logic [SIZEW-1:0] cfg_data    = '0;

	logic             busy;
	logic             strobe;
	logic [2:0]       kind;
	logic [7:0]       data_out;
	logic             last;
	logic [UCW-1:0]   used_count;
	logic             overflow_seen;

	rx_cmd_t    cmd_q[$];		// commands waiting to be driven
	rx_result_t reader_out_q[$];	// results the ring owes the reader, oldest first

	// Shadow of the ring: contents, indices, flags and the size register
	logic [7:0]  ring_mem [DEPTH_DEF];
	int unsigned wp       = 0;
	int unsigned rp       = 0;
	int unsigned slots    = DEPTH_DEF;
	int unsigned park_len = 0;
	bit          ovf_flag = 1'b0;
	bit          parked   = 1'b0;

	bit gap_enable = 1'b1;
	int quiet      = 0;
	int cycles     = 0;
	int n_queued   = 0;
	int n_items    = 0;
	int n_results  = 0;
	int n_cfg      = 0;
	int n_parks    = 0;
	int n_ovf      = 0;
	int n_fail     = 0;

	overwriting_byte_fifo u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.data_byte     (data_byte),
		.batch_last    (batch_last),
		.read_length   (read_length),
		.nonblocking   (nonblocking),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.strobe        (strobe),
		.kind          (kind),
		.data_out      (data_out),
		.last          (last),
		.used_count    (used_count),
		.overflow_seen (overflow_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Ring predictor
	// ---------------------------------------------------------------------

	function automatic int unsigned ring_next(int unsigned i);
		return (i + 1 >= slots) ? 0 : i + 1;
	endfunction

	function automatic void owe_result(kind_t k, logic [7:0] d, logic l, logic [UCW-1:0] u,
			logic o);
		rx_result_t r;
		r.k = k;
		r.d = d;
		r.l = l;
		r.u = u;
		r.o = o;
		reader_out_q.push_back(r);
	endfunction

	// Burst out up to limit bytes (never more than 64); last goes on the final byte
	function automatic int unsigned ring_drain(int unsigned limit);
		int unsigned n;
		n = 0;
		if (limit > DEPTH_DEF)
			limit = DEPTH_DEF;
		while (n < limit && wp != rp) begin
			owe_result(KIND_DATA, ring_mem[rp], 1'b0, '0, 1'b0);
			rp = ring_next(rp);
			n++;
		end
		if (n > 0)
			reader_out_q[$].l = 1'b1;
		return n;
	endfunction

	// Size write clamps to 2..DEPTH and empties the ring; overflow and a parked read survive
	function automatic void ring_resize(logic [SIZEW-1:0] v);
		slots = (v < 2) ? 2 : (v > DEPTH_DEF) ? DEPTH_DEF : v;
		wp = 0;
		rp = 0;
	endfunction

	function automatic void ring_apply(mode_t m, logic [7:0] b, logic bl,
			logic [LENW-1:0] len, logic nb);
		int unsigned used;
		case (m)
		MODE_BYTE: begin
			// always stored; a full ring drops its oldest byte and flags overflow
			ring_mem[wp] = b;
			wp = ring_next(wp);
			if (wp == rp) begin
				rp = ring_next(rp);
				ovf_flag = 1'b1;
			end
			// batch end wakes a parked read; a zero-length park serves nothing and stays
			if (bl && parked && ring_drain(park_len) > 0)
				parked = 1'b0;
		end
		MODE_READ: begin
			if (parked) begin
				owe_result(KIND_BUSY, '0, 1'b1, '0, 1'b0);
			end else if (ring_drain(32'(len)) == 0) begin
				// empty ring, or a zero-length read, which counts as empty
				if (nb) begin
					owe_result(KIND_WBLOCK, '0, 1'b1, '0, 1'b0);
				end else begin
					parked = 1'b1;
					park_len = 32'(len);
					n_parks++;
					owe_result(KIND_PARKED, '0, 1'b1, '0, 1'b0);
				end
			end
		end
		MODE_STATUS: begin
			used = (wp >= rp) ? wp - rp : slots - rp + wp;
			if (ovf_flag)
				n_ovf++;
			owe_result(KIND_STATUS, '0, 1'b1, used[UCW-1:0], ovf_flag);
			ovf_flag = 1'b0;
		end
		default: ;	// unused mode: taken, no effect
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Command queue helpers
	// ---------------------------------------------------------------------

	function automatic void push_item(mode_t m, logic [7:0] b, logic bl, logic [LENW-1:0] len,
			logic nb);
		rx_cmd_t c;
		c.act     = ACT_ITEM;
		c.md      = m;
		c.byt     = b;
		c.bl      = bl;
		c.len     = len;
		c.nb      = nb;
		c.size    = '0;
		c.may_gap = gap_enable;
		cmd_q.push_back(c);
		if (m != MODE_NONE)
			n_queued++;
	endfunction

	function automatic void push_ctl(step_t a, logic [SIZEW-1:0] v);
		rx_cmd_t c;
		c.act     = a;
		c.md      = MODE_NONE;
		c.byt     = '0;
		c.bl      = 1'b0;
		c.len     = '0;
		c.nb      = 1'b0;
		c.size    = v;
		c.may_gap = 1'b0;
		cmd_q.push_back(c);
	endfunction

	// ---------------------------------------------------------------------
	// Driver: predicts each accepted command, then launches the next queue entry.
	// start is assigned once per edge so a back-to-back command never drops it.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : p_drive
		logic    go;
		logic    cfg_go;
		rx_cmd_t c;
		if (!arst_n) begin
			start  <= 1'b0;
			cfg_we <= 1'b0;
			quiet  <= 0;
		end else begin
			go = start;
			cfg_go = 1'b0;
			if (start && !busy) begin
				// transfer taken at this edge
				ring_apply(mode_t'(mode), data_byte, batch_last, read_length, nonblocking);
				n_items++;
				go = 1'b0;
			end
			if (!go && cmd_q.size() > 0) begin
				c = cmd_q[0];
				if (c.act == ACT_ITEM) begin
					// random sender gaps, about 17 in a hundred, unless this stretch runs flat out
					if (!(c.may_gap && $urandom_range(0, 99) < 17)) begin
						void'(cmd_q.pop_front());
						go = 1'b1;
						mode        <= c.md;
						data_byte   <= c.byt;
						batch_last  <= c.bl;
						read_length <= c.len;
						nonblocking <= c.nb;
					end
				end else if (!start && !busy && !strobe && quiet >= SETTLE &&
						reader_out_q.size() == 0) begin
					// block idle and every owed result delivered
					void'(cmd_q.pop_front());
					if (c.act == ACT_CFG) begin
						cfg_go = 1'b1;
						cfg_data <= c.size;
						ring_resize(c.size);
						n_cfg++;
					end
				end
			end
			start  <= go;
			cfg_we <= cfg_go;
			quiet  <= (start || busy || strobe) ? 0 : quiet + 1;
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: every strobed cycle is a result transfer; no back-pressure exists.
	// ---------------------------------------------------------------------

	function automatic void field_chk(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_fail++;
		end
	endfunction

	always @(posedge clk) begin : p_check
		rx_result_t e;
		if (arst_n && strobe) begin
			n_results++;
			if (reader_out_q.size() == 0) begin
				$error("result with nothing owed: kind %0d data %0h", kind, data_out);
				n_fail++;
			end else begin
				e = reader_out_q.pop_front();
				field_chk("kind", e.k, kind);
				field_chk("data_out", e.d, data_out);
				field_chk("last", e.l, last);
				field_chk("used_count", e.u, used_count);
				field_chk("overflow_seen", e.o, overflow_seen);
			end
		end
	end

	// Watchdog against a hung handshake or a missing result
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("overwriting_byte_fifo verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus plan and end of run
	// ---------------------------------------------------------------------
	initial begin
		int r;
		int r2;
		int n;
		int phase;
		logic [LENW-1:0] len;

		// --- directed, ring at its reset size of 64 ---
		push_item(MODE_STATUS, 8'h00, 1'b0, 7'd0, 1'b0);	// empty ring reports zero used
		push_item(MODE_READ, 8'h00, 1'b0, 7'd5, 1'b1);		// empty, nonblocking: would-block
		push_item(MODE_READ, 8'h00, 1'b0, 7'd0, 1'b1);		// zero length, nonblocking
		push_item(MODE_NONE, 8'hFF, 1'b1, 7'd127, 1'b1);	// unused mode: dropped
		push_item(MODE_READ, 8'h00, 1'b0, 7'd3, 1'b0);		// empty, blocking: parks
		push_item(MODE_READ, 8'h00, 1'b0, 7'd5, 1'b1);		// read while parked: busy
		push_item(MODE_BYTE, 8'h00, 1'b0, 7'd0, 1'b0);
		push_item(MODE_BYTE, 8'hFF, 1'b1, 7'd0, 1'b0);		// batch end serves the park
		push_item(MODE_BYTE, 8'h3C, 1'b0, 7'd0, 1'b0);
		push_item(MODE_READ, 8'h00, 1'b0, 7'd0, 1'b1);		// zero length counts as empty
		push_item(MODE_READ, 8'h00, 1'b0, 7'd127, 1'b0);	// length beyond 64 is capped

		// smallest ring: one usable slot, second byte overwrites the first
		push_ctl(ACT_HOLD, '0);
		push_ctl(ACT_CFG, 7'd0);
		push_item(MODE_BYTE, 8'hA5, 1'b0, 7'd0, 1'b0);
		push_item(MODE_BYTE, 8'h5A, 1'b1, 7'd0, 1'b0);
		push_item(MODE_STATUS, 8'h00, 1'b0, 7'd0, 1'b0);	// overflow seen
		push_item(MODE_STATUS, 8'h00, 1'b0, 7'd0, 1'b0);	// and cleared
		push_item(MODE_READ, 8'h00, 1'b0, 7'd1, 1'b0);

		// five slots, six bytes: wraps and overflows
		push_ctl(ACT_HOLD, '0);
		push_ctl(ACT_CFG, 7'd5);
		for (int i = 0; i < 6; i++)
			push_item(MODE_BYTE, 8'h01 << i, i == 5, 7'd0, 1'b0);
		push_item(MODE_STATUS, 8'h00, 1'b0, 7'd0, 1'b0);
		push_item(MODE_READ, 8'h00, 1'b0, 7'd64, 1'b1);

		// a parked read survives a size write
		push_item(MODE_READ, 8'h00, 1'b0, 7'd2, 1'b0);
		push_ctl(ACT_HOLD, '0);
		push_ctl(ACT_CFG, 7'd127);
		push_item(MODE_BYTE, 8'h77, 1'b1, 7'd0, 1'b0);

		// --- random phases, one size setting each ---
		n_queued = 0;
		phase = 0;
		while (n_queued < RAND_ITEMS) begin
			push_ctl(ACT_HOLD, '0);
			push_ctl(ACT_CFG, SIZE_PLAN[phase % 8]);
			gap_enable = (phase != 0);	// one phase with the sender never idle
			for (int k = 0; k < 25 && n_queued < RAND_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					// arrival batch; now and then long enough to wrap a big ring
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 6);
					for (int i = 0; i < n; i++)
						push_item(MODE_BYTE, 8'($urandom),
							(i == n - 1) ? ($urandom_range(0, 9) != 0)
							: ($urandom_range(0, 19) == 0), 7'($urandom), 1'($urandom));
				end else if (r < 75) begin
					// blocking reads never use length zero: that park could never be served
					r2 = $urandom_range(0, 99);
					if (r2 < 5) begin
						push_item(MODE_READ, 8'($urandom), 1'($urandom), 7'd0, 1'b1);
					end else begin
						len = (r2 < 85) ? 7'($urandom_range(1, 12)) : 7'($urandom_range(13, 127));
						push_item(MODE_READ, 8'($urandom), 1'($urandom), len,
							1'($urandom_range(0, 1)));
					end
				end else if (r < 90) begin
					push_item(MODE_STATUS, 8'($urandom), 1'($urandom), 7'($urandom),
						1'($urandom));
				end else begin
					push_item(MODE_NONE, 8'($urandom), 1'($urandom), 7'($urandom),
						1'($urandom));
				end
				if ($urandom_range(0, 39) == 0)
					push_ctl(ACT_HOLD, '0);		// sender waits for the reader to catch up
			end
			phase++;
		end

		// --- closing: a zero-length park is permanent, so it comes last ---
		gap_enable = 1'b1;
		push_ctl(ACT_HOLD, '0);
		push_item(MODE_BYTE, 8'hC3, 1'b1, 7'd0, 1'b0);		// releases any pending park
		push_item(MODE_READ, 8'h00, 1'b0, 7'd64, 1'b1);		// empty the ring
		push_item(MODE_READ, 8'h00, 1'b0, 7'd0, 1'b0);		// parks with length zero
		push_item(MODE_BYTE, 8'h9E, 1'b1, 7'd0, 1'b0);		// nothing served
		push_item(MODE_READ, 8'h00, 1'b0, 7'd4, 1'b0);		// still parked: busy
		push_item(MODE_STATUS, 8'h00, 1'b0, 7'd0, 1'b0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// all commands sent and every owed result seen, then let stray strobes show up
		do @(negedge clk);
		while (cmd_q.size() != 0 || start || reader_out_q.size() != 0);
		repeat (SETTLE * 3) @(negedge clk);

		$display("covered %0d command transfers, %0d results checked, %0d size writes",
			n_items, n_results, n_cfg);
		$display("reads parked %0d times, overflow reported %0d times", n_parks, n_ovf);
		if (n_fail == 0 && reader_out_q.size() == 0) begin
			$display("overwriting_byte_fifo verification clean");
		end else begin
			$display("overwriting_byte_fifo verification failed");
		end
		$finish;
	end

endmodule
